>>> design/bfra_pkg.sv
// shared types, constants and command structs of the best-fit range allocator
package bfra_pkg;

   localparam int MAX_GAPS_DEFAULT  = 32;
   localparam int ADDR_BITS_DEFAULT = 32;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   typedef struct packed {
      logic        cmd;
      logic [31:0] request_size;
      logic [31:0] request_alignment;
      logic [31:0] free_start;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] taken_start;
      logic [31:0] taken_size;
      logic [31:0] usable_start;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_DIV,
      ST_EVAL,
      ST_FINISH,
      ST_COMMIT,
      ST_COMMIT2,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic capture;
      logic resp_zero;
      logic idx_clr;
      logic idx_inc;
      logic mem_rd;
      logic eval;
      logic div_start;
      logic div_step;
      logic finish;
      logic commit;
      logic commit2;
   } ctrl_cmd_type;

   typedef struct packed {
      logic idx_last;
      logic is_free;
      logic entry_used;
      logic align_zero;
      logic div_last;
      logic merge_both;
   } dp_status_type;

endpackage

>>> design/bfra_ctrl.sv
// controller state machine of the best-fit range allocator
module bfra_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  bfra_pkg::req_type      req_data,
   input  bfra_pkg::dp_status_type stat,
   output bfra_pkg::ctrl_cmd_type cmd
);

   bfra_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfra_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfra_pkg::ST_CLEAR: begin
            if (stat.idx_last) state_in = bfra_pkg::ST_IDLE;
         end
         bfra_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_data.cmd == bfra_pkg::CMD_FREE && req_data.request_size == '0)
                  state_in = bfra_pkg::ST_RESP;
               else
                  state_in = bfra_pkg::ST_SCAN_RD;
            end
         end
         bfra_pkg::ST_SCAN_RD: state_in = bfra_pkg::ST_SCAN_CHK;
         bfra_pkg::ST_SCAN_CHK: begin
            if (!stat.is_free && stat.entry_used && !stat.align_zero)
               state_in = bfra_pkg::ST_DIV;
            else if (stat.idx_last)
               state_in = bfra_pkg::ST_FINISH;
            else
               state_in = bfra_pkg::ST_SCAN_RD;
         end
         bfra_pkg::ST_DIV: begin
            if (stat.div_last) state_in = bfra_pkg::ST_EVAL;
         end
         bfra_pkg::ST_EVAL: begin
            if (stat.idx_last) state_in = bfra_pkg::ST_FINISH;
            else state_in = bfra_pkg::ST_SCAN_RD;
         end
         bfra_pkg::ST_FINISH: state_in = bfra_pkg::ST_COMMIT;
         bfra_pkg::ST_COMMIT: begin
            if (stat.is_free && stat.merge_both) state_in = bfra_pkg::ST_COMMIT2;
            else state_in = bfra_pkg::ST_RESP;
         end
         bfra_pkg::ST_COMMIT2: state_in = bfra_pkg::ST_RESP;
         bfra_pkg::ST_RESP: begin
            if (rsp_ready) state_in = bfra_pkg::ST_IDLE;
         end
         default: state_in = bfra_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         bfra_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.idx_inc  = !stat.idx_last;
            cmd.idx_clr  = stat.idx_last;
         end
         bfra_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture   = 1'b1;
               cmd.idx_clr   = 1'b1;
               cmd.resp_zero = 1'b1;
            end
         end
         bfra_pkg::ST_SCAN_RD: cmd.mem_rd = 1'b1;
         bfra_pkg::ST_SCAN_CHK: begin
            if (!stat.is_free && stat.entry_used && !stat.align_zero) begin
               cmd.div_start = 1'b1;
            end else begin
               cmd.eval    = 1'b1;
               cmd.idx_inc = !stat.idx_last;
            end
         end
         bfra_pkg::ST_DIV: cmd.div_step = 1'b1;
         bfra_pkg::ST_EVAL: begin
            cmd.eval    = 1'b1;
            cmd.idx_inc = !stat.idx_last;
         end
         bfra_pkg::ST_FINISH: cmd.finish = 1'b1;
         bfra_pkg::ST_COMMIT: cmd.commit = 1'b1;
         bfra_pkg::ST_COMMIT2: cmd.commit2 = 1'b1;
         bfra_pkg::ST_RESP: rsp_valid = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule

>>> design/bfra_dp.sv
// datapath of the best-fit range allocator: gap table, remainder unit, selection
module bfra_dp #(
   parameter int MAX_GAPS  = bfra_pkg::MAX_GAPS_DEFAULT,
   parameter int ADDR_BITS = bfra_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bfra_pkg::req_type       req_data,
   input  bfra_pkg::ctrl_cmd_type  cmd,
   output bfra_pkg::dp_status_type stat,
   output bfra_pkg::rsp_type       rsp_data
);

   localparam int A  = ADDR_BITS;
   localparam int IW = (MAX_GAPS > 1) ? $clog2(MAX_GAPS) : 1;
   localparam int CW = $clog2(ADDR_BITS);
   localparam int EW = 2 * A + 1;

   // table entry: used, begin, length
   logic [EW-1:0] mem_ff [MAX_GAPS];
   logic [EW-1:0] rd_ff;
   logic          we;
   logic [IW-1:0] wa;
   logic [EW-1:0] wd;

   logic          cmd_ff, cmd_in;
   logic [A-1:0]  size_ff, size_in, align_ff, align_in, start_ff, start_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [A-1:0]  rem_ff, rem_in, dvd_ff, dvd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          best_found_ff, best_found_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic [A-1:0]  best_begin_ff, best_begin_in, best_len_ff, best_len_in;
   logic [A-1:0]  best_pad_ff, best_pad_in;
   logic          bef_found_ff, bef_found_in;
   logic [IW-1:0] bef_idx_ff, bef_idx_in;
   logic [A-1:0]  bef_begin_ff, bef_begin_in, bef_len_ff, bef_len_in;
   logic          aft_found_ff, aft_found_in;
   logic [IW-1:0] aft_idx_ff, aft_idx_in;
   logic [A-1:0]  aft_len_ff, aft_len_in;
   logic          emp_found_ff, emp_found_in;
   logic [IW-1:0] emp_idx_ff, emp_idx_in;
   logic [A-1:0]  acc_ff, acc_in;
   bfra_pkg::rsp_type rsp_ff, rsp_in;

   logic          e_used;
   logic [A-1:0]  e_begin, e_len, pad, avail, diff_b, diff_a, sel_len, usable;
   logic [A:0]    rem_shift, sum1, sum2;
   logic          fits, better;

   assign e_used  = rd_ff[EW-1];
   assign e_begin = rd_ff[2*A-1:A];
   assign e_len   = rd_ff[A-1:0];

   assign pad   = (align_ff == '0 || rem_ff == '0) ? '0 : align_ff - rem_ff;
   assign avail = e_len - pad;
   assign fits  = (pad <= e_len) && (size_ff <= avail);
   assign better = !best_found_ff || (e_len < best_len_ff) ||
                   (e_len == best_len_ff && e_begin < best_begin_ff);
   assign diff_b = start_ff - e_begin;
   assign diff_a = e_begin - start_ff;
   assign rem_shift = {rem_ff, dvd_ff[A-1]};
   assign sel_len = bef_found_ff ? bef_len_ff : aft_len_ff;
   assign sum1 = {1'b0, sel_len} + {1'b0, size_ff};
   assign sum2 = {1'b0, acc_ff} + {1'b0, aft_len_ff};
   assign usable = best_begin_ff + best_pad_ff;

   assign stat.idx_last   = (idx_ff == IW'(MAX_GAPS - 1));
   assign stat.is_free    = (cmd_ff == bfra_pkg::CMD_FREE);
   assign stat.entry_used = e_used;
   assign stat.align_zero = (align_ff == '0);
   assign stat.div_last   = (cnt_ff == CW'(A - 1));
   assign stat.merge_both = bef_found_ff && aft_found_ff;
   assign rsp_data        = rsp_ff;

   always_comb begin
      cmd_in = cmd_ff; size_in = size_ff; align_in = align_ff; start_in = start_ff;
      idx_in = idx_ff; rem_in = rem_ff; dvd_in = dvd_ff; cnt_in = cnt_ff;
      best_found_in = best_found_ff; best_idx_in = best_idx_ff;
      best_begin_in = best_begin_ff; best_len_in = best_len_ff; best_pad_in = best_pad_ff;
      bef_found_in = bef_found_ff; bef_idx_in = bef_idx_ff;
      bef_begin_in = bef_begin_ff; bef_len_in = bef_len_ff;
      aft_found_in = aft_found_ff; aft_idx_in = aft_idx_ff; aft_len_in = aft_len_ff;
      emp_found_in = emp_found_ff; emp_idx_in = emp_idx_ff;
      acc_in = acc_ff; rsp_in = rsp_ff;
      we = 1'b0; wa = idx_ff; wd = '0;

      if (cmd.clear_wr) we = 1'b1;
      if (cmd.idx_clr) idx_in = '0;
      if (cmd.idx_inc) idx_in = idx_ff + 1'b1;

      if (cmd.capture) begin
         cmd_in   = req_data.cmd;
         size_in  = A'(req_data.request_size);
         align_in = A'(req_data.request_alignment);
         start_in = A'(req_data.free_start);
         rem_in   = '0;
         best_found_in = 1'b0; bef_found_in = 1'b0;
         aft_found_in  = 1'b0; emp_found_in = 1'b0;
      end
      if (cmd.resp_zero) rsp_in = '0;

      // restoring remainder, one bit of the gap start a cycle
      if (cmd.div_start) begin
         rem_in = '0; dvd_in = e_begin; cnt_in = '0;
      end
      if (cmd.div_step) begin
         if (rem_shift >= {1'b0, align_ff}) rem_in = A'(rem_shift - {1'b0, align_ff});
         else rem_in = rem_shift[A-1:0];
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff + 1'b1;
      end

      if (cmd.eval && e_used) begin
         if (cmd_ff == bfra_pkg::CMD_ALLOC) begin
            if (fits && better) begin
               best_found_in = 1'b1; best_idx_in = idx_ff;
               best_begin_in = e_begin; best_len_in = e_len; best_pad_in = pad;
            end
         end else if (!bef_found_ff && start_ff >= e_begin && diff_b == e_len) begin
            bef_found_in = 1'b1; bef_idx_in = idx_ff;
            bef_begin_in = e_begin; bef_len_in = e_len;
         end else if (!aft_found_ff && e_begin >= start_ff && diff_a == size_ff) begin
            aft_found_in = 1'b1; aft_idx_in = idx_ff; aft_len_in = e_len;
         end
      end
      if (cmd.eval && !e_used && !emp_found_ff) begin
         emp_found_in = 1'b1; emp_idx_in = idx_ff;
      end

      if (cmd.finish) begin
         if (cmd_ff == bfra_pkg::CMD_ALLOC) acc_in = size_ff + best_pad_ff;
         else acc_in = sum1[A] ? '1 : sum1[A-1:0];
      end

      if (cmd.commit) begin
         rsp_in = '0;
         if (cmd_ff == bfra_pkg::CMD_ALLOC) begin
            if (best_found_ff) begin
               we = 1'b1; wa = best_idx_ff;
               if (acc_ff == best_len_ff) wd = '0;
               else wd = {1'b1, best_begin_ff + acc_ff, best_len_ff - acc_ff};
               rsp_in.status       = bfra_pkg::STATUS_OK;
               rsp_in.taken_start  = 32'(best_begin_ff);
               rsp_in.taken_size   = 32'(acc_ff);
               rsp_in.usable_start = 32'(usable);
            end else begin
               rsp_in.status = bfra_pkg::STATUS_NO_FIT;
            end
         end else begin
            rsp_in.status = bfra_pkg::STATUS_OK;
            if (bef_found_ff && aft_found_ff) begin
               we = 1'b1; wa = bef_idx_ff;
               wd = {1'b1, bef_begin_ff, sum2[A] ? {A{1'b1}} : sum2[A-1:0]};
            end else if (bef_found_ff) begin
               we = 1'b1; wa = bef_idx_ff; wd = {1'b1, bef_begin_ff, acc_ff};
            end else if (aft_found_ff) begin
               we = 1'b1; wa = aft_idx_ff; wd = {1'b1, start_ff, acc_ff};
            end else if (emp_found_ff) begin
               we = 1'b1; wa = emp_idx_ff; wd = {1'b1, start_ff, size_ff};
            end else begin
               rsp_in.status = bfra_pkg::STATUS_FULL;
            end
         end
      end
      if (cmd.commit2) begin
         we = 1'b1; wa = aft_idx_ff; wd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem_ff[wa] <= wd;
      if (cmd.mem_rd) rd_ff <= mem_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         best_found_ff <= 1'b0;
         bef_found_ff  <= 1'b0;
         aft_found_ff  <= 1'b0;
         emp_found_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         idx_ff        <= idx_in;
         best_found_ff <= best_found_in;
         bef_found_ff  <= bef_found_in;
         aft_found_ff  <= aft_found_in;
         emp_found_ff  <= emp_found_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; size_ff <= size_in; align_ff <= align_in; start_ff <= start_in;
      rem_ff <= rem_in; dvd_ff <= dvd_in;
      best_idx_ff <= best_idx_in; best_begin_ff <= best_begin_in;
      best_len_ff <= best_len_in; best_pad_ff <= best_pad_in;
      bef_idx_ff <= bef_idx_in; bef_begin_ff <= bef_begin_in; bef_len_ff <= bef_len_in;
      aft_idx_ff <= aft_idx_in; aft_len_ff <= aft_len_in;
      emp_idx_ff <= emp_idx_in;
      acc_ff <= acc_in; rsp_ff <= rsp_in;
   end

endmodule

>>> design/best_fit_range_allocator_top.sv
// top level of the best-fit range allocator: controller plus datapath
// one transaction at a time; a free scans the whole table, with an extra write-back step when it
// merges on both sides; a zero-size free goes straight to the result
// an allocate scans the whole table and, when alignment is non-zero, runs the bit-serial remainder
// unit for each occupied gap; the scan reads the table through the single table read port
// after reset a clearing pass empties the gap table entry by entry; no request is taken then
// the result waits in an output register until taken; the next request is accepted from the cycle after
module best_fit_range_allocator_top #(
   parameter int MAX_GAPS  = bfra_pkg::MAX_GAPS_DEFAULT,
   parameter int ADDR_BITS = bfra_pkg::ADDR_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bfra_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bfra_pkg::rsp_type rsp_data
);

   // command and status between controller and datapath
   bfra_pkg::ctrl_cmd_type  cmd;
   bfra_pkg::dp_status_type stat;

   // sequencer: clearing pass, table scan, remainder wait, write-back, result
   bfra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .req_data  (req_data),
      .stat      (stat),
      .cmd       (cmd)
   );

   // gap table, best-fit tracking, merge search and result register
   bfra_dp #(
      .MAX_GAPS  (MAX_GAPS),
      .ADDR_BITS (ADDR_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

>>> tb/sv/tb_best_fit_range_allocator_checker.sv
// checker of the best-fit range allocator: watches both channels, predicts and compares
module tb_best_fit_range_allocator_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  bfra_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  bfra_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GAPS = bfra_pkg::MAX_GAPS_DEFAULT;

   logic [31:0]       gap_start_q [GAPS];
   logic [31:0]       gap_len_q [GAPS];
   logic              gap_live_q [GAPS];
   bfra_pkg::rsp_type expected_rsp_q [$];

   function automatic logic [31:0] align_pad(logic [31:0] start, logic [31:0] align);
      logic [31:0] rem;
      if (align == 0) return 0;
      rem = start % align;
      return (rem != 0) ? align - rem : 0;
   endfunction

   function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hffff_ffff : s[31:0];
   endfunction

   function automatic bfra_pkg::rsp_type allocate_range(logic [31:0] size,
                                                        logic [31:0] align);
      bfra_pkg::rsp_type r;
      int                best;
      logic [31:0]       best_pad, pad, taken;
      r = '0;
      best = -1;
      best_pad = 0;
      for (int i = 0; i < GAPS; i++) begin
         if (!gap_live_q[i]) continue;
         pad = align_pad(gap_start_q[i], align);
         if (pad > gap_len_q[i] || size > gap_len_q[i] - pad) continue;
         if (best < 0 || gap_len_q[i] < gap_len_q[best] ||
             (gap_len_q[i] == gap_len_q[best] && gap_start_q[i] < gap_start_q[best])) begin
            best = i;
            best_pad = pad;
         end
      end
      if (best < 0) begin
         r.status = bfra_pkg::STATUS_NO_FIT;
         return r;
      end
      taken = size + best_pad;
      r.status = bfra_pkg::STATUS_OK;
      r.taken_start = gap_start_q[best];
      r.taken_size = taken;
      r.usable_start = gap_start_q[best] + best_pad;
      if (taken == gap_len_q[best]) begin
         gap_live_q[best] = 0;
         gap_start_q[best] = 0;
         gap_len_q[best] = 0;
      end else begin
         gap_start_q[best] = gap_start_q[best] + taken;
         gap_len_q[best] = gap_len_q[best] - taken;
      end
      return r;
   endfunction

   function automatic bfra_pkg::rsp_type free_range(logic [31:0] start, logic [31:0] size);
      bfra_pkg::rsp_type r;
      int                lo, hi, empty;
      r = '0;
      r.status = bfra_pkg::STATUS_OK;
      lo = -1;
      hi = -1;
      empty = -1;
      if (size == 0) return r;
      for (int i = 0; i < GAPS; i++) begin
         if (!gap_live_q[i]) begin
            if (empty < 0) empty = i;
            continue;
         end
         if (lo < 0 && start >= gap_start_q[i] && start - gap_start_q[i] == gap_len_q[i])
            lo = i;
         else if (hi < 0 && gap_start_q[i] >= start && gap_start_q[i] - start == size)
            hi = i;
      end
      if (lo >= 0 && hi >= 0) begin
         gap_len_q[lo] = add_sat(add_sat(gap_len_q[lo], size), gap_len_q[hi]);
         gap_live_q[hi] = 0;
         gap_start_q[hi] = 0;
         gap_len_q[hi] = 0;
      end else if (lo >= 0) begin
         gap_len_q[lo] = add_sat(gap_len_q[lo], size);
      end else if (hi >= 0) begin
         gap_start_q[hi] = start;
         gap_len_q[hi] = add_sat(gap_len_q[hi], size);
      end else if (empty >= 0) begin
         gap_live_q[empty] = 1;
         gap_start_q[empty] = start;
         gap_len_q[empty] = size;
      end else begin
         r.status = bfra_pkg::STATUS_FULL;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      bfra_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < GAPS; i++) begin
            gap_start_q[i] = 0;
            gap_len_q[i] = 0;
            gap_live_q[i] = 0;
         end
         expected_rsp_q.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_data.cmd == bfra_pkg::CMD_ALLOC)
               expected_rsp_q = {expected_rsp_q,
                                 allocate_range(req_data.request_size,
                                                req_data.request_alignment)};
            else
               expected_rsp_q = {expected_rsp_q,
                                 free_range(req_data.free_start, req_data.request_size)};
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected response %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsp_q.pop_front();
               if (want !== rsp_data) begin
                  if (fail_count < 10) $display("mismatch: expected %p, got %p", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= expected_rsp_q.size();
   end

endmodule

>>> tb/sv/tb_best_fit_range_allocator_top.sv
// testbench top of the best-fit range allocator: clock, reset, stimulus and verdict
module tb_best_fit_range_allocator_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   bfra_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   bfra_pkg::rsp_type rsp_data;
   int                fail_count;
   int                pending_count;
   int                cycle_count = 0;
   bit                quiet_stretch = 0;

   // live allocations, so frees mostly hand back real ranges and merges happen
   logic [31:0] held_start [$];
   logic [31:0] held_size [$];

   always #4 clock = ~clock;

   best_fit_range_allocator_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   tb_best_fit_range_allocator_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // remember successful allocations for later frees
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && rsp_data.status == bfra_pkg::STATUS_OK &&
          rsp_data.taken_size != 0) begin
         held_start = {held_start, rsp_data.taken_start};
         held_size = {held_size, rsp_data.taken_size};
      end
   end

   // receiver stalls at random, with a chance of 19 in a hundred, never during the quiet stretch
   always @(posedge clock) begin
      rsp_ready <= quiet_stretch ? 1'b1 : ($urandom_range(99) >= 19);
   end

   // watchdog: ends the run with a failure verdict once the cycle counter passes its limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 10_000_000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_transaction(logic c, logic [31:0] size, logic [31:0] align,
                                   logic [31:0] start);
      bfra_pkg::req_type t;
      t.cmd = c;
      t.request_size = size;
      t.request_alignment = align;
      t.free_start = start;
      // random idle gap before the transaction
      if (!quiet_stretch && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (!quiet_stretch && $urandom_range(99) < 19);
      end
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random;
      int          k, pick;
      logic [31:0] a;
      k = $urandom_range(99);
      if (k < 40) begin
         // allocate: modest sizes; alignment zero, a small power of two, a small value or fully random
         case ($urandom_range(3))
            0: a = 0;
            1: a = 32'd1 << $urandom_range(8);
            2: a = $urandom_range(1, 100);
            default: a = $urandom();
         endcase
         send_transaction(bfra_pkg::CMD_ALLOC, $urandom_range(0, 4096), a, $urandom());
      end else if (k < 75 && held_start.size() > 0) begin
         // hand back a live allocation
         pick = $urandom_range(held_start.size() - 1);
         send_transaction(bfra_pkg::CMD_FREE, held_size[pick], $urandom(), held_start[pick]);
         held_start.delete(pick);
         held_size.delete(pick);
      end else if (k < 90) begin
         // fresh region, sometimes adjacent to earlier ones
         send_transaction(bfra_pkg::CMD_FREE, $urandom_range(0, 1 << 16), $urandom(),
                          (32'($urandom_range(0, 15)) << 16) +
                          32'($urandom_range(0, 3)) * 32'h1000);
      end else begin
         // noise across the full field range
         send_transaction(1'($urandom_range(1)), $urandom(), $urandom(), $urandom());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-table allocate, zero-size free, exact fit, merges, extremes
      send_transaction(bfra_pkg::CMD_ALLOC, 32'd16, 32'd0, 32'd0);
      send_transaction(bfra_pkg::CMD_FREE, 32'd0, 32'd0, 32'h1000);
      send_transaction(bfra_pkg::CMD_FREE, 32'h100, 32'hffff_ffff, 32'h1000);
      send_transaction(bfra_pkg::CMD_FREE, 32'h100, 32'd0, 32'h1200);
      send_transaction(bfra_pkg::CMD_FREE, 32'h100, 32'd0, 32'h1100);
      send_transaction(bfra_pkg::CMD_ALLOC, 32'd0, 32'd0, 32'hffff_ffff);
      send_transaction(bfra_pkg::CMD_ALLOC, 32'd0, 32'd64, 32'd0);
      send_transaction(bfra_pkg::CMD_ALLOC, 32'd10, 32'd7, 32'd0);
      send_transaction(bfra_pkg::CMD_ALLOC, 32'hffff_ffff, 32'd0, 32'd0);
      send_transaction(bfra_pkg::CMD_ALLOC, 32'd0, 32'hffff_ffff, 32'd0);
      send_transaction(bfra_pkg::CMD_FREE, 32'hffff_ffff, 32'd0, 32'hffff_fff0);
      send_transaction(bfra_pkg::CMD_FREE, 32'h10, 32'd0, 32'h0);
      send_transaction(bfra_pkg::CMD_FREE, 32'hffff_ffff, 32'd0, 32'h10);
      send_transaction(bfra_pkg::CMD_ALLOC, 32'h2, 32'h8000_0000, 32'd0);
      send_transaction(bfra_pkg::CMD_ALLOC, 32'h0, 32'd1, 32'd0);
      // fill the table with isolated gaps to reach the full case
      for (int i = 0; i < 34; i++)
         send_transaction(bfra_pkg::CMD_FREE, 32'd8, 32'd0, 32'h4000_0000 + i * 32'h100);
      send_transaction(bfra_pkg::CMD_ALLOC, 32'd8, 32'd0, 32'd0);

      // random, with a quiet stretch in the middle
      for (int n = 0; n < 1350; n++) begin
         quiet_stretch = (n >= 600 && n < 750);
         send_random();
         // reset nothing and no explicit draining of the table between items
      end
      quiet_stretch = 0;
      req_valid <= 1'b0;

      // let the checker see the last request before waiting on the results
      @(posedge clock);
      while (pending_count != 0 || rsp_valid) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> filelist.f
design/bfra_pkg.sv
design/bfra_ctrl.sv
design/bfra_dp.sv
design/best_fit_range_allocator_top.sv
tb/sv/tb_best_fit_range_allocator_checker.sv
tb/sv/tb_best_fit_range_allocator_top.sv
